/* hdl/baro_sensor_temp_pressure_compensation_macros.svh */
// Assertion macros shared by the barometric compensation RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BARO_SENSOR_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bsc_pkg.sv */
// Package for the barometric compensation block: widths, constants, shared types.
// Depends on nothing.
package bsc_pkg;

  localparam int RawW   = 20;
  localparam int TempW  = 32;
  localparam int PressW = 24;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam int QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegTemp   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPLow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPHigh  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPNine  = 2'd3;

  // Work item handed from the front (temperature) to the back (pressure).
  typedef struct packed {
    logic [RawW-1:0]  raw_pressure;
    logic [TempW-1:0] tfine;
    logic [TempW-1:0] temperature;
  } bsc_item_t;

  // Result item leaving the back part.
  typedef struct packed {
    logic             divisor_zero;
    logic [PressW-1:0] pressure;
    logic [TempW-1:0] temperature;
  } bsc_result_t;

  // Calibration words as one bundle.
  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_nine;
  } bsc_cal_t;

endpackage

/* hdl/bsc_front.sv */
// Front part: accepts raw readings and computes temperature and fine temperature.
// Depends on bsc_pkg.
module bsc_front
  import bsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [47:0]     temp_coeffs_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [RawW-1:0] raw_temperature_i,
  input  logic [RawW-1:0] raw_pressure_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output bsc_item_t       item_o
);

  // Stage valid flags and payloads of a three-stage pipeline.
  logic s1_q, s2_q, s3_q;
  logic adv1, adv2, adv3;
  logic [31:0] diff1_q, d_q, t2_q, t3_q;
  logic [RawW-1:0] rp1_q, rp2_q, rp3_q;
  logic [31:0] a_q, dd_q, t3b_q;
  logic [31:0] tfine_q, temp_q;

  logic [31:0] t1, t2, t3, adc_t, diff1, dval, prod_a, prod_dd, b_val, tf, tmul;

  assign adv3 = !s3_q || item_ready_i;
  assign adv2 = !s2_q || adv3;
  assign adv1 = !s1_q || adv2;
  assign in_ready_o = adv1;

  // Stage 1: coefficient extraction and differences.
  always_comb begin
    t1 = {16'd0, temp_coeffs_i[15:0]};
    t2 = {{16{temp_coeffs_i[31]}}, temp_coeffs_i[31:16]};
    t3 = {{16{temp_coeffs_i[47]}}, temp_coeffs_i[47:32]};
    adc_t = {12'd0, raw_temperature_i};
    diff1 = (adc_t >> 3) - (t1 << 1);
    dval = (adc_t >> 4) - t1;
  end

  // Stage 2: the two multiplications.
  always_comb begin
    prod_a = diff1_q * t2_q;
    prod_dd = d_q * d_q;
  end

  // Stage 3: remaining products and the final scale.
  always_comb begin
    b_val = $signed($signed(dd_q) * $signed(t3b_q)) >>> 14;
    tf = a_q + b_val;
    tmul = tf * 32'd5 + 32'd128;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      if (adv1) s1_q <= in_valid_i;
      if (adv2) s2_q <= s1_q;
      if (adv3) s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      diff1_q <= diff1;
      d_q <= dval;
      t2_q <= t2;
      t3_q <= t3;
      rp1_q <= raw_pressure_i;
    end
    if (adv2 && s1_q) begin
      a_q <= 32'($signed(prod_a) >>> 11);
      dd_q <= 32'($signed(prod_dd) >>> 12);
      t3b_q <= t3_q;
      rp2_q <= rp1_q;
    end
    if (adv3 && s2_q) begin
      tfine_q <= tf;
      temp_q <= 32'($signed(tmul) >>> 8);
      rp3_q <= rp2_q;
    end
  end

  assign item_valid_o = s3_q;
  assign item_o = '{raw_pressure: rp3_q, tfine: tfine_q, temperature: temp_q};

endmodule

/* hdl/bsc_queue.sv */
// Short queue between the front and back parts.
// Depends on bsc_pkg.
module bsc_queue
  import bsc_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  bsc_item_t wr_data_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output bsc_item_t rd_data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  bsc_item_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = cnt_q != (PtrW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_en) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* hdl/bsc_divider.sv */
// Iterative signed 64-bit divider, truncating toward zero, one bit per cycle.
// Depends on bsc_pkg.
module bsc_divider
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        neg_q, busy_q, done_q;
  logic [64:0] trial;
  logic [63:0] shifted;

  // One restoring step: shift in next numerator bit and try to subtract.
  always_comb begin
    shifted = {rem_q[62:0], quo_q[63]};
    trial = {1'b0, shifted} - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= num_i[63] ? 64'(0 - num_i) : num_i;
      den_q <= den_i[63] ? 64'(0 - den_i) : den_i;
      neg_q <= num_i[63] ^ den_i[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? 64'(0 - quo_q) : quo_q;

endmodule

/* hdl/bsc_back.sv */
// Back part: pressure polynomial with 64-bit intermediates on a shared 32x32 multiplier.
// Depends on bsc_pkg, bsc_divider and the assertion macro header.
`include "baro_sensor_temp_pressure_compensation_macros.svh"
module bsc_back
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bsc_cal_t    cal_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  bsc_item_t   item_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output bsc_result_t res_o
);
  typedef enum logic [2:0] {
    StIdle, StLoad, StMul, StStore, StCheck, StDiv, StFinal, StOut
  } state_e;

  // The 64-bit products, taken in this order on the shared multiplier.
  typedef enum logic [3:0] {
    OpV1Sq, OpV1P5, OpV1P2, OpSqP6, OpSqP3, OpP1, OpNum, OpP9, OpP8, OpPh
  } mul_op_e;

  state_e st_q;
  mul_op_e op_q;
  logic [1:0]  mstep_q;
  logic [63:0] v1_q, v1sq_q, v2_q, acc_q, p_q, ph_q, t_q, u_q;
  logic [63:0] ma_q, mb_q, mres_q;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [RawW-1:0] rp_q;
  logic [TempW-1:0] temp_q;
  logic        zf_q;
  logic        res_valid_q, res_load;
  bsc_result_t res_q;
  logic        div_start, div_busy, div_done;
  logic [63:0] div_q;
  logic [63:0] op_a, op_b;
  logic [20:0] p_diff;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  always_comb begin
    p1 = {48'd0, cal_i.press_low[15:0]};
    p2 = {{48{cal_i.press_low[31]}}, cal_i.press_low[31:16]};
    p3 = {{48{cal_i.press_low[47]}}, cal_i.press_low[47:32]};
    p4 = {{48{cal_i.press_low[63]}}, cal_i.press_low[63:48]};
    p5 = {{48{cal_i.press_high[15]}}, cal_i.press_high[15:0]};
    p6 = {{48{cal_i.press_high[31]}}, cal_i.press_high[31:16]};
    p7 = {{48{cal_i.press_high[47]}}, cal_i.press_high[47:32]};
    p8 = {{48{cal_i.press_high[63]}}, cal_i.press_high[63:48]};
    p9 = {{48{cal_i.press_nine[15]}}, cal_i.press_nine};
    p_diff = 21'h100000 - {1'b0, rp_q};
  end

  // Operand selection for the product in turn.
  always_comb begin
    op_a = v1_q;
    op_b = v1_q;
    unique case (op_q)
      OpV1Sq: op_a = v1_q;
      OpV1P5: op_a = v1_q;
      OpV1P2: op_a = v1_q;
      OpSqP6: op_a = v1sq_q;
      OpSqP3: op_a = v1sq_q;
      OpP1:   op_a = 64'h0000_8000_0000_0000 + acc_q;
      OpNum:  op_a = ({43'd0, p_diff} << 31) - v2_q;
      OpP9:   op_a = p9;
      OpP8:   op_a = p8;
      OpPh:   op_a = t_q;
      default: ;
    endcase
    unique case (op_q)
      OpV1Sq: op_b = v1_q;
      OpV1P5: op_b = p5;
      OpV1P2: op_b = p2;
      OpSqP6: op_b = p6;
      OpSqP3: op_b = p3;
      OpP1:   op_b = p1;
      OpNum:  op_b = 64'd3125;
      OpP9:   op_b = ph_q;
      OpP8:   op_b = p_q;
      OpPh:   op_b = ph_q;
      default: ;
    endcase
  end

  // Low 64 bits of a product from three 32x32 partial products, one per cycle.
  always_comb begin
    mul_a = (mstep_q == 2'd2) ? ma_q[63:32] : ma_q[31:0];
    mul_b = (mstep_q == 2'd1) ? mb_q[63:32] : mb_q[31:0];
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  assign div_start = (st_q == StStore) && (op_q == OpNum);
  assign item_ready_o = (st_q == StIdle);
  assign res_load = (st_q == StOut) && (!res_valid_q || res_ready_i);

  bsc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mres_q),
    .den_i  (acc_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // Sequencer: state, product index and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      op_q <= OpV1Sq;
      mstep_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
        res_q <= '{divisor_zero: zf_q, pressure: zf_q ? 24'd0 : p_q[31:8],
                   temperature: temp_q};
      end else if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (item_valid_i) begin
            op_q <= OpV1Sq;
            st_q <= StLoad;
          end
        end
        StLoad: begin
          mstep_q <= '0;
          st_q <= StMul;
        end
        StMul: begin
          mstep_q <= mstep_q + 2'd1;
          if (mstep_q == 2'd2) st_q <= StStore;
        end
        StStore: begin
          unique case (op_q)
            OpP1:  st_q <= StCheck;
            OpNum: st_q <= StDiv;
            OpPh:  st_q <= StFinal;
            default: begin
              op_q <= mul_op_e'(op_q + 4'd1);
              st_q <= StLoad;
            end
          endcase
        end
        StCheck: begin
          if (acc_q == '0) begin
            st_q <= StOut;
          end else begin
            op_q <= OpNum;
            st_q <= StLoad;
          end
        end
        StDiv: begin
          if (div_done) begin
            op_q <= OpP9;
            st_q <= StLoad;
          end
        end
        StFinal: st_q <= StOut;
        StOut:   if (res_load) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // Working registers of the polynomial.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (item_valid_i) begin
          v1_q <= {{32{item_i.tfine[31]}}, item_i.tfine} - 64'd128000;
          rp_q <= item_i.raw_pressure;
          temp_q <= item_i.temperature;
        end
      end
      StLoad: begin
        ma_q <= op_a;
        mb_q <= op_b;
      end
      StMul: begin
        if (mstep_q == 2'd0) mres_q <= prod;
        else mres_q[63:32] <= mres_q[63:32] + prod[31:0];
      end
      StStore: begin
        unique case (op_q)
          OpV1Sq: v1sq_q <= mres_q;
          OpV1P5: t_q <= mres_q;
          OpV1P2: u_q <= mres_q;
          OpSqP6: v2_q <= mres_q + (t_q << 17) + (p4 << 35);
          OpSqP3: acc_q <= 64'($signed(mres_q) >>> 8) + (u_q << 12);
          OpP1:   acc_q <= 64'($signed(mres_q) >>> 33);
          OpP9:   t_q <= mres_q;
          OpP8:   u_q <= 64'($signed(mres_q) >>> 19);
          OpPh:   t_q <= 64'($signed(mres_q) >>> 25);
          // The scaled numerator goes straight into the divider.
          default: ;
        endcase
      end
      StCheck: zf_q <= (acc_q == '0);
      StDiv: begin
        if (div_done) begin
          p_q <= div_q;
          ph_q <= 64'($signed(div_q) >>> 13);
        end
      end
      StFinal: begin
        p_q <= 64'($signed(p_q + t_q + u_q) >>> 8) + (p7 << 4);
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  `BSC_ASSERT_IMPL(a_div_only_in_div, clk_i, rst_ni, div_busy, st_q == StDiv, "divider busy outside divide state")
  `BSC_ASSERT_IMPL(a_zero_flag_pressure, clk_i, rst_ni, res_valid_q && res_q.divisor_zero, res_q.pressure == '0, "zero divisor with nonzero pressure")
  `BSC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_q && !res_ready_i, res_valid_q && $stable(res_q), "result changed while stalled")

endmodule

/* hdl/baro_sensor_temp_pressure_compensation.sv */
// Top level of the barometric compensation block: config registers and wiring.
// Depends on bsc_pkg, bsc_front, bsc_queue and bsc_back.
//
// Takes one raw temperature/pressure pair per transfer and returns one result with the
// temperature in 0.01 degC, pressure in Pa and a flag for a zero pressure divisor. A
// three-stage temperature pipeline takes a new item every cycle unless the queue stalls it,
// and passes it through a two-entry queue to the pressure unit, which works on one item at
// a time. It forms ten 64-bit products (six when the divisor is zero), each made of operand
// load, three 32x32 partial products on one multiplier and store, and, unless the divisor
// is zero, runs the bit-serial 64-bit divider, one quotient bit a cycle. A finished result
// waits in an output register, so the next item is already worked on while the receiver
// stalls. Configuration writes are accepted at any time and must only be issued while the
// block is idle.
module baro_sensor_temp_pressure_compensation
  import bsc_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [19:0] raw_temperature, [39:20] raw_pressure, [47:40] zero
  input  logic [47:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] temperature_centi, [55:32] pressure_pascal
  output logic [55:0]         m_axis_tdata,
  // [0] divisor_zero
  output logic                m_axis_tuser
);
  bsc_cal_t cal_q;
  logic f_valid, f_ready, b_valid, b_ready;
  bsc_item_t f_item, b_item;
  bsc_result_t res;

  assign cfg_ready_o = 1'b1;

  // Calibration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTemp:  cal_q.temp_coeffs <= cfg_data_i[47:0];
        RegPLow:  cal_q.press_low <= cfg_data_i;
        RegPHigh: cal_q.press_high <= cfg_data_i;
        RegPNine: cal_q.press_nine <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .temp_coeffs_i(cal_q.temp_coeffs),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .raw_temperature_i(s_axis_tdata[19:0]), .raw_pressure_i(s_axis_tdata[39:20]),
    .item_valid_o(f_valid), .item_ready_i(f_ready), .item_o(f_item)
  );

  bsc_queue #(.Depth(QDepth)) u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_item)
  );

  bsc_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cal_i(cal_q),
    .item_valid_i(b_valid), .item_ready_o(b_ready), .item_i(b_item),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {res.pressure, res.temperature};
  assign m_axis_tuser = res.divisor_zero;

endmodule
